@@ rtl/rledb_pkg.sv @@
// shared types, constants and helpers for the doubled-byte run-length encoder
// no dependencies

package rledb_pkg;

  // value held as the previous byte after reset and after each stream end
  localparam logic [7:0] PrevReset = 8'hFF;
  // longest counted run before a count goes out and counting restarts
  localparam logic [7:0] CountMax  = 8'd255;

  // job queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // one encoded output byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       is_count;
    logic       last_of_item;
    logic       stream_done;
  } rledb_res_t;

  // everything one request leaves for the back end: one or two results
  typedef struct packed {
    logic       two;
    rledb_res_t r0;
    rledb_res_t r1;
  } rledb_job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } rledb_qstat_t;

  function automatic rledb_res_t mk_data(input logic [7:0] b);
    rledb_res_t r;
    r.data         = b;
    r.is_count     = 1'b0;
    r.last_of_item = 1'b0;
    r.stream_done  = 1'b0;
    return r;
  endfunction

  function automatic rledb_res_t mk_count(input logic [7:0] c);
    rledb_res_t r;
    r.data         = c;
    r.is_count     = 1'b1;
    r.last_of_item = 1'b0;
    r.stream_done  = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/rledb_ifs.sv @@
// valid/ready channel interfaces for the encoder's input and result sides
// no dependencies

interface rledb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface rledb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_count;
  logic       last_of_item;
  logic       stream_done;

  modport source (output valid, output out_byte, output is_count, output last_of_item,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input is_count, input last_of_item,
                  input stream_done, output ready);
endinterface

@@ rtl/rledb_front.sv @@
// front end: accepts raw bytes, tracks the run state, builds result jobs
// depends on rledb_pkg

module rledb_front
  import rledb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  input  logic         stream_end,
  input  rledb_qstat_t qstat,
  output logic         push,
  output rledb_job_t   push_job
);

  logic [7:0] prev_r, prev_nxt;
  logic [7:0] rc_r, rc_nxt;
  logic [1:0] n;
  rledb_res_t r0, r1;
  logic       accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    n        = 2'd0;
    r0       = mk_data(in_byte);
    r1       = mk_data(in_byte);
    prev_nxt = prev_r;
    rc_nxt   = rc_r;

    if (in_byte == prev_r) begin
      if (rc_r == CountMax) begin
        r0     = mk_count(CountMax);
        n      = 2'd1;
        rc_nxt = '0;
      end else begin
        if (rc_r == '0) begin
          r0 = mk_data(in_byte);
          n  = 2'd1;
        end
        rc_nxt = rc_r + 8'd1;
      end
    end else begin
      if (rc_r != '0) begin
        r0 = mk_count(rc_r - 8'd1);
        r1 = mk_data(in_byte);
        n  = 2'd2;
      end else begin
        r0 = mk_data(in_byte);
        n  = 2'd1;
      end
      prev_nxt = in_byte;
      rc_nxt   = '0;
    end

    // flush a pending count at stream end, then back to reset state
    if (stream_end) begin
      if (rc_nxt != '0 && n != 2'd2) begin
        if (n == 2'd0) begin
          r0 = mk_count(rc_nxt - 8'd1);
          n  = 2'd1;
        end else begin
          r1 = mk_count(rc_nxt - 8'd1);
          n  = 2'd2;
        end
      end
      prev_nxt = PrevReset;
      rc_nxt   = '0;
    end

    if (n == 2'd2) begin
      r1.last_of_item = 1'b1;
      r1.stream_done  = stream_end;
    end else begin
      r0.last_of_item = 1'b1;
      r0.stream_done  = stream_end;
    end
  end

  assign push         = accept && (n != 2'd0);
  assign push_job.two = (n == 2'd2);
  assign push_job.r0  = r0;
  assign push_job.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= PrevReset;
      rc_r   <= '0;
    end else if (accept) begin
      prev_r <= prev_nxt;
      rc_r   <= rc_nxt;
    end
  end

endmodule

@@ rtl/rledb_queue.sv @@
// short job queue between front and back ends
// depends on rledb_pkg

module rledb_queue
  import rledb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  rledb_job_t   push_job,
  input  logic         pop,
  output rledb_job_t   pop_job,
  output rledb_qstat_t qstat
);

  rledb_job_t       ent_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r;
  logic [QAw-1:0]   rd_ptr_r;
  logic [QCw-1:0]   cnt_r;

  assign qstat.full  = (cnt_r == QCw'(QDepth));
  assign qstat.empty = (cnt_r == '0);
  assign pop_job     = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QAw'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QAw'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_job;
  end

endmodule

@@ rtl/rledb_back.sv @@
// back end: plays each job out as one or two results through an output register
// depends on rledb_pkg

module rledb_back
  import rledb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rledb_qstat_t qstat,
  input  rledb_job_t   pop_job,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output rledb_res_t   out_res
);

  logic       out_valid_r, out_valid_nxt;
  rledb_res_t out_r, out_nxt;
  logic       sec_valid_r, sec_valid_nxt;
  rledb_res_t sec_r, sec_nxt;
  logic       load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    pop           = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    if (load) begin
      priority if (sec_valid_r) begin
        out_nxt       = sec_r;
        out_valid_nxt = 1'b1;
        sec_valid_nxt = 1'b0;
      end else if (!qstat.empty) begin
        pop           = 1'b1;
        out_nxt       = pop_job.r0;
        out_valid_nxt = 1'b1;
        sec_valid_nxt = pop_job.two;
        sec_nxt       = pop_job.r1;
      end else begin
        // nothing left to send
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ rtl/rle_doubled_byte_encoder.sv @@
// Doubled-byte run-length encoder. Each request carries one raw byte and a
// stream_end flag; each gives zero, one or two encoded bytes. A byte that
// differs from the one before goes out as data; a second equal byte goes out
// again as data, and further copies are counted, the count (copies beyond
// the doubled pair) going out as a count byte when the run ends, at stream
// end, or as 255 when the counter saturates. Throughput is one request per
// cycle while requests give at most one result and the output is not
// stalled; a request that gives two results sends them one after the other
// through the single output register and the one-byte-wide result channel.
// With the pipeline idle, a request's first result passes the job queue and
// then the output register before it shows at the output. A two-entry job
// queue lets input and output stall independently.
// depends on rledb_pkg, rledb_ifs, rledb_front, rledb_queue, rledb_back

module rle_doubled_byte_encoder
  import rledb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rledb_in_if.sink    in_ch,
  rledb_out_if.source out_ch
);

  // front to queue
  logic         push;
  rledb_job_t   push_job;
  // queue to back
  logic         pop;
  rledb_job_t   pop_job;
  rledb_qstat_t qstat;
  // result register
  rledb_res_t   out_res;
  logic         out_valid;

  // classify each request and update the run state
  rledb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .stream_end (in_ch.stream_end),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  // decouples front from back
  rledb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  // emit the results of each job in order
  rledb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.out_byte     = out_res.data;
  assign out_ch.is_count     = out_res.is_count;
  assign out_ch.last_of_item = out_res.last_of_item;
  assign out_ch.stream_done  = out_res.stream_done;

endmodule

@@ rtl/rledb_checker.sv @@
// port-level checks for the doubled-byte run-length encoder, bound to the top level
// depends on rle_doubled_byte_encoder

module rledb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_count,
  input logic       last_of_item,
  input logic       stream_done
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_count)
      && $stable(last_of_item) && $stable(stream_done))
    else $error("stalled result changed");

  // the stream's final byte is also the final result of its request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> last_of_item)
    else $error("stream_done without last_of_item");

  // reset leaves nothing to send and room for a request
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind rle_doubled_byte_encoder rledb_checker u_rledb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .is_count     (out_ch.is_count),
  .last_of_item (out_ch.last_of_item),
  .stream_done  (out_ch.stream_done)
);

@@ dv/tb.sv @@
// self-checking testbench for the doubled-byte run-length encoder
// depends on rledb_pkg, rledb_ifs and the rle_doubled_byte_encoder top level

`timescale 1ns / 100ps

module tb;
  import rledb_pkg::*;

  // watchdog limit: cycles in a row with no request or result accepted
  localparam int StallLimit = 2000;
  // cycles to wait after the last expected result before ending the run
  localparam int TailCycles = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rledb_in_if  in_if ();
  rledb_out_if out_if ();

  // result-side ready is a plain register so it is known from time zero
  logic sink_ready = 1'b0;
  assign out_if.ready = sink_ready;

  rle_doubled_byte_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // encoder state as predicted from the accepted requests
  logic [7:0] prev_byte;
  logic [7:0] run_cnt;

  // encoded bytes that are still due at the output, oldest first
  rledb_res_t pending_codes[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  function automatic rledb_res_t code_byte(input logic [7:0] value, input logic is_cnt);
    rledb_res_t r;
    r.data         = value;
    r.is_count     = is_cnt;
    r.last_of_item = 1'b0;
    r.stream_done  = 1'b0;
    return r;
  endfunction

  // predicts the encoded bytes for one accepted request and queues them
  task automatic encode_byte(input logic [7:0] b, input logic last_in_stream);
    rledb_res_t res[2];
    int n;
    n = 0;
    if (b == prev_byte) begin
      if (run_cnt == CountMax) begin
        // counter saturated: full count goes out, next equal byte is data again
        res[n] = code_byte(CountMax, 1'b1);
        n++;
        run_cnt = 8'd0;
      end else begin
        // the doubled copy goes out once, later copies are only counted
        if (run_cnt == 8'd0) begin
          res[n] = code_byte(b, 1'b0);
          n++;
        end
        run_cnt = run_cnt + 8'd1;
      end
    end else begin
      // a new byte closes any open run with its count first
      if (run_cnt != 8'd0) begin
        res[n] = code_byte(run_cnt - 8'd1, 1'b1);
        n++;
      end
      run_cnt   = 8'd0;
      res[n]    = code_byte(b, 1'b0);
      n++;
      prev_byte = b;
    end
    if (last_in_stream) begin
      // flush an open run, mark the stream end and start over from reset values
      if (run_cnt != 8'd0 && n < 2) begin
        res[n] = code_byte(run_cnt - 8'd1, 1'b1);
        n++;
      end
      if (n > 0) res[n-1].stream_done = 1'b1;
      prev_byte = PrevReset;
      run_cnt   = 8'd0;
    end
    if (n > 0) res[n-1].last_of_item = 1'b1;
    for (int i = 0; i < n; i++) pending_codes.push_back(res[i]);
  endtask

  // one request: random idle gap, then hold valid until the handshake
  task automatic send_byte(input logic [7:0] b, input logic last_in_stream);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.stream_end <= last_in_stream;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    encode_byte(b, last_in_stream);
  endtask

  // hold off the sender until every queued result has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  // field extremes, first byte equal to the reset value, single-byte streams,
  // runs closed by a new byte and by the stream end
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b1);
    drain_results();
  endtask

  // runs long enough to saturate the counter, ended right on the count
  // and one byte later
  task automatic test_saturating_runs();
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    for (int i = 0; i < 257; i++) send_byte(8'h3C, i == 256);
    for (int i = 0; i < 258; i++) send_byte(8'hC3, i == 257);
    drain_results();
  endtask

  // random streams of up to 60 bytes, heavy on repeats so runs of many lengths show up
  task automatic test_random_streams(input int n_items, input int send_pct, input int recv_pct);
    int sent;
    int len;
    logic [7:0] b;
    logic [7:0] last_b;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent   = 0;
    last_b = 8'($urandom_range(255));
    // start each phase from an empty pipeline
    drain_results();
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0, 1: b = last_b;
          2: b = 8'($urandom_range(255));
          default: b = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        send_byte(b, i == len - 1);
        last_b = b;
        sent++;
      end
      if ($urandom_range(7) == 0) drain_results();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every accepted result is compared with the oldest prediction
  always @(posedge clk) begin
    rledb_res_t want;
    if (rst_n && out_if.valid && sink_ready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: mismatch, no result expected, actual byte 0x%0h count %0b",
                 $time, out_if.out_byte, out_if.is_count);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        check_field("out_byte", want.data, out_if.out_byte);
        check_field("is_count", want.is_count, out_if.is_count);
        check_field("last_of_item", want.last_of_item, out_if.last_of_item);
        check_field("stream_done", want.stream_done, out_if.stream_done);
      end
    end
  end

  // watchdog: ends the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && sink_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, StallLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= 8'h00;
    in_if.stream_end <= 1'b0;
    prev_byte = PrevReset;
    run_cnt   = 8'd0;
    // synchronous reset, held low and released before the first test
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_saturating_runs();
    test_random_streams(170, 0, 0);
    test_random_streams(160, 71, 0);
    test_random_streams(160, 0, 71);
    test_random_streams(160, 37, 37);

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (pending_codes.size() != 0) begin
      $display("%0t: %0d results never came", $time, pending_codes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rledb_pkg.sv
rtl/rledb_ifs.sv
rtl/rledb_front.sv
rtl/rledb_queue.sv
rtl/rledb_back.sv
rtl/rle_doubled_byte_encoder.sv
rtl/rledb_checker.sv
dv/tb.sv
